@@ hdl/bwem_pkg.sv @@
package bwem_pkg;

    // configuration port shape
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MIN_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_SUM_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_SUM_HIGH = 3'd4;

    // register reset values
    localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd2048;
    localparam logic [11:0] RST_IMAGE_HEIGHT   = 12'd2048;
    localparam logic [7:0]  RST_BLUE_MIN_LEVEL = 8'd50;
    localparam logic [9:0]  RST_WHITE_SUM_LOW  = 10'd600;
    localparam logic [9:0]  RST_WHITE_SUM_HIGH = 10'd750;

    // frame height limits
    localparam logic [11:0] MIN_HEIGHT = 12'd2;
    localparam logic [11:0] MAX_HEIGHT = 12'd2048;

    localparam int ROW_W = 11;
    localparam int OUT_COL_W = 11;

    // queue depths
    localparam int JOB_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    // per-pixel job flags from front to back
    typedef struct packed {
        logic has_main;   // column behind the pixel gets its mark
        logic has_end;    // pixel closes the row
        logic last_row;   // row is the last of the frame
    } job_flags_t;

    // one result beat
    typedef struct packed {
        logic                 mask_bit;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 frame_done;
    } res_t;

endpackage

@@ hdl/blue_white_edge_mask_stream.sv @@
// Path: a pixel's beats pass through the job queue, the operation stage and the result queue,
// and the row-end beat follows the main beat. Any work already waiting in the queues delays them.
// Throughput: one pixel per cycle while full is low; the pixel that closes a row, unless it is
// in column 0, gives two operations, main then row end, one line-store read-modify-write each; row 0 gives no beats.
// Reset: registers take their defaults; the line store is then cleared, one column per
// cycle across all MAX_WIDTH columns, while full stays high. cfg_ready is always high.
module blue_white_edge_mask_stream #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // pixel queue side
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       pix_blue,
    input  logic [7:0]                       pix_green,
    input  logic [7:0]                       pix_red,
    // mask queue side
    output logic                             empty,
    input  logic                             pop,
    output logic                             mask_bit,
    output logic [10:0]                      out_row,
    output logic [10:0]                      out_col,
    output logic                             frame_done,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bwem_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bwem_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int JOB_W = bwem_pkg::ROW_W + COLW + 1 + $bits(bwem_pkg::job_flags_t);
    localparam int RES_W = $bits(bwem_pkg::res_t);

    logic                        accept;
    logic                        clear_busy;
    logic                        job_push, job_full, job_empty, job_pop;
    logic [bwem_pkg::ROW_W-1:0]  f_row, b_row;
    logic [COLW-1:0]             f_col, b_col;
    logic                        f_mark, b_mark;
    bwem_pkg::job_flags_t        f_flags, b_flags;
    logic [JOB_W-1:0]            job_wr, job_rd;
    logic                        res_push, res_full;
    bwem_pkg::res_t              res_in, res_out;
    logic [RES_W-1:0]            res_rd;

    assign cfg_ready = 1'b1;
    assign full      = job_full || clear_busy;
    assign accept    = push && !full;

    // classify pixels and track the raster position
    bwem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pix_blue  (pix_blue),
        .pix_green (pix_green),
        .pix_red   (pix_red),
        .job_push  (job_push),
        .job_row   (f_row),
        .job_col   (f_col),
        .job_mark  (f_mark),
        .job_flags (f_flags)
    );

    // job queue between front and back
    assign job_wr = {f_row, f_col, f_mark, f_flags};
    assign {b_row, b_col, b_mark, b_flags} = job_rd;

    bwem_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (bwem_pkg::JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_wr),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_rd),
        .empty   (job_empty)
    );

    // line store update and mask build
    bwem_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (!job_empty),
        .job_row    (b_row),
        .job_col    (b_col),
        .job_mark   (b_mark),
        .job_flags  (b_flags),
        .job_pop    (job_pop),
        .res_valid  (res_push),
        .res_data   (res_in),
        .res_full   (res_full),
        .clear_busy (clear_busy)
    );

    // result queue
    bwem_fifo #(
        .WIDTH (RES_W),
        .DEPTH (bwem_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign res_out    = res_rd;
    assign mask_bit   = res_out.mask_bit;
    assign out_row    = res_out.row;
    assign out_col    = res_out.col;
    assign frame_done = res_out.frame_done;

endmodule

@@ hdl/bwem_fifo.sv @@
module bwem_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             wr_ok, rd_ok;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign wr_ok   = wr_en && !full;
    assign rd_ok   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ok ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_ok ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_ok && !rd_ok)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (rd_ok && !wr_ok)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/bwem_front.sv @@
module bwem_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr,
    input  logic [bwem_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bwem_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                accept,
    input  logic [7:0]                          pix_blue,
    input  logic [7:0]                          pix_green,
    input  logic [7:0]                          pix_red,
    output logic                                job_push,
    output logic [bwem_pkg::ROW_W-1:0]          job_row,
    output logic [$clog2(MAX_WIDTH)-1:0]        job_col,
    output logic                                job_mark,
    output bwem_pkg::job_flags_t                job_flags
);

    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int WW   = COLW + 1;
    localparam int CMPW = (WW > bwem_pkg::CFG_DATA_W) ? WW : bwem_pkg::CFG_DATA_W;
    localparam int MW   = COLW + 2;
    localparam int HW   = bwem_pkg::ROW_W + 2;

    logic [11:0] image_width_reg;
    logic [11:0] image_height_reg;
    logic [7:0]  blue_min_reg;
    logic [9:0]  sum_low_reg;
    logic [9:0]  sum_high_reg;

    logic [bwem_pkg::ROW_W-1:0] row_reg, row_next;
    logic [COLW-1:0]            col_reg, col_next;
    logic [1:0]                 blue_bits_reg, blue_bits_next;
    logic [1:0]                 white_bits_reg, white_bits_next;

    logic [CMPW-1:0] w_sat;
    logic [WW-1:0]   w_eff;
    logic [COLW-1:0] last_col, cur_col, mark_col;
    logic [11:0]     h_eff;
    logic            row_end, last_row, has_main;
    logic            col_ok, row_ok;
    logic [10:0]     blue_x5, green_x7, red_x7;
    logic [9:0]      sum, min_x4;
    logic [7:0]      min_ch;
    logic            blue_cur, white_cur, mark;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bwem_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= bwem_pkg::RST_IMAGE_HEIGHT;
            blue_min_reg     <= bwem_pkg::RST_BLUE_MIN_LEVEL;
            sum_low_reg      <= bwem_pkg::RST_WHITE_SUM_LOW;
            sum_high_reg     <= bwem_pkg::RST_WHITE_SUM_HIGH;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                bwem_pkg::CFG_IMAGE_WIDTH:    image_width_reg  <= cfg_data;
                bwem_pkg::CFG_IMAGE_HEIGHT:   image_height_reg <= cfg_data;
                bwem_pkg::CFG_BLUE_MIN_LEVEL: blue_min_reg     <= cfg_data[7:0];
                bwem_pkg::CFG_WHITE_SUM_LOW:  sum_low_reg      <= cfg_data[9:0];
                bwem_pkg::CFG_WHITE_SUM_HIGH: sum_high_reg     <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // effective frame size and current position
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            w_sat = CMPW'(1);
        end
        else if (CMPW'(image_width_reg) > CMPW'(MAX_WIDTH))
        begin
            w_sat = CMPW'(MAX_WIDTH);
        end
        else
        begin
            w_sat = CMPW'(image_width_reg);
        end
        w_eff    = WW'(w_sat);
        last_col = COLW'(w_eff - WW'(1));
        cur_col  = (col_reg > last_col) ? last_col : col_reg;
        row_end  = (cur_col == last_col);
        has_main = (cur_col != '0);
        mark_col = cur_col - COLW'(1);

        if (image_height_reg < bwem_pkg::MIN_HEIGHT)
        begin
            h_eff = bwem_pkg::MIN_HEIGHT;
        end
        else if (image_height_reg > bwem_pkg::MAX_HEIGHT)
        begin
            h_eff = bwem_pkg::MAX_HEIGHT;
        end
        else
        begin
            h_eff = image_height_reg;
        end
        last_row = (HW'(row_reg) + HW'(1)) >= HW'(h_eff);

        // marks only inside the frame, clear of the border band
        col_ok = (mark_col >= COLW'(2)) && ((MW'(mark_col) + MW'(4)) <= MW'(w_eff));
        row_ok = (row_reg >= bwem_pkg::ROW_W'(2)) && ((HW'(row_reg) + HW'(4)) <= HW'(h_eff));
    end

    // pixel classification
    always_comb
    begin
        blue_x5  = (11'(pix_blue) << 2) + 11'(pix_blue);
        green_x7 = (11'(pix_green) << 3) - 11'(pix_green);
        red_x7   = (11'(pix_red) << 3) - 11'(pix_red);
        blue_cur = (blue_x5 > green_x7) && (blue_x5 > red_x7) && (pix_blue > blue_min_reg);

        sum    = 10'(pix_blue) + 10'(pix_green) + 10'(pix_red);
        min_ch = (pix_blue < pix_green) ? pix_blue : pix_green;
        if (pix_red < min_ch)
        begin
            min_ch = pix_red;
        end
        min_x4    = {min_ch, 2'b00};
        white_cur = ((sum != '0) && (min_x4 >= sum))
                 || ((sum >= sum_low_reg) && (sum < sum_high_reg));

        // neighbours of the column behind: two pixels back and this one
        mark = row_ok && col_ok && (blue_bits_reg[1] || blue_cur)
            && (white_bits_reg[1] || white_cur);
    end

    // job to the back end
    assign job_push           = accept && (has_main || row_end);
    assign job_row            = row_reg;
    assign job_col            = cur_col;
    assign job_mark           = mark;
    assign job_flags.has_main = has_main;
    assign job_flags.has_end  = row_end;
    assign job_flags.last_row = last_row;

    // raster position and class history
    always_comb
    begin
        row_next        = row_reg;
        col_next        = col_reg;
        blue_bits_next  = blue_bits_reg;
        white_bits_next = white_bits_reg;
        if (accept)
        begin
            blue_bits_next  = {blue_bits_reg[0], blue_cur};
            white_bits_next = {white_bits_reg[0], white_cur};
            if (row_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + bwem_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = cur_col + COLW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg        <= '0;
            col_reg        <= '0;
            blue_bits_reg  <= '0;
            white_bits_reg <= '0;
        end
        else
        begin
            row_reg        <= row_next;
            col_reg        <= col_next;
            blue_bits_reg  <= blue_bits_next;
            white_bits_reg <= white_bits_next;
        end
    end

endmodule

@@ hdl/bwem_back.sv @@
module bwem_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    input  logic [bwem_pkg::ROW_W-1:0]     job_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]   job_col,
    input  logic                           job_mark,
    input  bwem_pkg::job_flags_t           job_flags,
    output logic                           job_pop,
    output logic                           res_valid,
    output bwem_pkg::res_t                 res_data,
    input  logic                           res_full,
    output logic                           clear_busy
);

    localparam int COLW = $clog2(MAX_WIDTH);

    // line store: bit 1 second previous row, bit 0 previous row
    logic [1:0] line_mem [MAX_WIDTH];

    logic            clear_busy_reg, clear_busy_next;
    logic [COLW-1:0] clear_addr_reg, clear_addr_next;
    logic            phase_reg, phase_next;

    logic            s1_valid_reg, s1_valid_next;
    logic [COLW-1:0] s1_col_reg;
    logic [bwem_pkg::ROW_W-1:0] s1_row_reg;
    logic            s1_mark_reg;
    logic            s1_done_reg;
    logic [1:0]      rd_mem_reg;
    logic            fwd_hit_reg;
    logic [1:0]      fwd_val_reg;

    logic            issue_main, op_last, can_issue;
    logic [COLW-1:0] op_col;
    logic            op_mark, op_done;
    logic            s1_emit, s1_fire;
    logic [1:0]      s1_line;
    logic            mem_we;
    logic [COLW-1:0] mem_waddr;
    logic [1:0]      mem_wdata;

    assign clear_busy = clear_busy_reg;

    // split a job into its column operations
    always_comb
    begin
        issue_main = job_flags.has_main && !phase_reg;
        op_last    = !(issue_main && job_flags.has_end);
        op_col     = issue_main ? job_col - COLW'(1) : job_col;
        op_mark    = issue_main && job_mark;
        op_done    = !issue_main && job_flags.last_row;
    end

    // operation stage
    assign s1_emit   = (s1_row_reg != '0);
    assign s1_fire   = s1_valid_reg && (!s1_emit || !res_full);
    assign can_issue = job_valid && !clear_busy_reg && (!s1_valid_reg || s1_fire);
    assign job_pop   = can_issue && op_last;
    assign s1_line   = fwd_hit_reg ? fwd_val_reg : rd_mem_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        s1_valid_next = s1_valid_reg;
        if (can_issue)
        begin
            phase_next    = !op_last;
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // result beat
    assign res_valid           = s1_fire && s1_emit;
    assign res_data.mask_bit   = ((s1_row_reg >= bwem_pkg::ROW_W'(2)) && s1_line[1])
                               || s1_line[0] || s1_mark_reg;
    assign res_data.row        = s1_row_reg - bwem_pkg::ROW_W'(1);
    assign res_data.col        = bwem_pkg::OUT_COL_W'(s1_col_reg);
    assign res_data.frame_done = s1_done_reg;

    // post-reset clearing of the line store
    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_busy_reg)
        begin
            clear_addr_next = clear_addr_reg + COLW'(1);
            if (clear_addr_reg == COLW'(MAX_WIDTH - 1))
            begin
                clear_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        mem_we    = clear_busy_reg || s1_fire;
        mem_waddr = clear_busy_reg ? clear_addr_reg : s1_col_reg;
        mem_wdata = clear_busy_reg ? 2'b00 : {s1_line[0], s1_mark_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            phase_reg      <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            phase_reg      <= phase_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    // stage payload, line store read with bypass of the write in flight
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (can_issue)
        begin
            rd_mem_reg  <= line_mem[op_col];
            fwd_hit_reg <= s1_fire && (s1_col_reg == op_col);
            fwd_val_reg <= {s1_line[0], s1_mark_reg};
            s1_col_reg  <= op_col;
            s1_row_reg  <= job_row;
            s1_mark_reg <= op_mark;
            s1_done_reg <= op_done;
        end
    end

    // checks
    a_no_op_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !s1_valid_reg)
        else $error("operation in flight during line store clear");

    a_end_pending_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> job_valid)
        else $error("row end pending without a job at the queue head");

    a_stall_holds_op: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stalled operation lost or changed");

    a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !res_full)
        else $error("result beat pushed into a full queue");

    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (job_valid && !clear_busy_reg))
        else $error("job popped while not available");

endmodule
